// ===== sv/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared widths, constants and types for the token scanner: the result record
// and the per-character bundle that the front end hands to the back end.
// ----------------------------------------------------------------------------
package lts_pkg;

    // offset and line counter widths
    localparam int OFFSET_BITS = 20;
    localparam int LINE_BITS   = 20;

    // widths of the result fields
    localparam int TYPE_W   = 5;
    localparam int FIELD_W  = 20;

    // most results that one source byte or the finish command can cause
    localparam int MAX_RES  = 3;
    localparam int RIDX_W   = $clog2(MAX_RES);

    // bundle queue between front and back end
    localparam int QUEUE_DEPTH = 4;

    // one token or error report
    typedef struct packed {
        logic              is_error;
        logic              error_code;
        logic [TYPE_W-1:0] tok_kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
    } result_t;

    // all results caused by one input item; they share one line number
    typedef struct packed {
        logic [RIDX_W-1:0]          count;
        logic [FIELD_W-1:0]         line;
        result_t [MAX_RES-1:0]      res;
    } bundle_t;

endpackage

// ===== sv/lts_front.sv =====
// ----------------------------------------------------------------------------
// lts_front
// Scanner front end: keeps the scan mode, pending operator, token start,
// offset and line count, and turns each accepted item that yields results into a bundle.
// ----------------------------------------------------------------------------
module lts_front
    import lts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       command,
    input  logic [7:0] char_code,
    output logic       wr_en,
    output bundle_t    wr_data
);

    // scan modes
    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_OP      = 3'd1;
    localparam logic [2:0] MODE_SLASH   = 3'd2;
    localparam logic [2:0] MODE_COMMENT = 3'd3;
    localparam logic [2:0] MODE_STRING  = 3'd4;
    localparam logic [2:0] MODE_INT     = 3'd5;
    localparam logic [2:0] MODE_DOT     = 3'd6;
    localparam logic [2:0] MODE_FRAC    = 3'd7;

    // pending operator codes
    localparam logic [1:0] OP_BANG    = 2'd0;
    localparam logic [1:0] OP_EQ      = 2'd1;
    localparam logic [1:0] OP_LESS    = 2'd2;
    localparam logic [1:0] OP_GREATER = 2'd3;

    // token types
    localparam logic [TYPE_W-1:0] TOK_LPAREN  = 5'd0;
    localparam logic [TYPE_W-1:0] TOK_RPAREN  = 5'd1;
    localparam logic [TYPE_W-1:0] TOK_LBRACE  = 5'd2;
    localparam logic [TYPE_W-1:0] TOK_RBRACE  = 5'd3;
    localparam logic [TYPE_W-1:0] TOK_COMMA   = 5'd4;
    localparam logic [TYPE_W-1:0] TOK_DOT     = 5'd5;
    localparam logic [TYPE_W-1:0] TOK_MINUS   = 5'd6;
    localparam logic [TYPE_W-1:0] TOK_PLUS    = 5'd7;
    localparam logic [TYPE_W-1:0] TOK_SEMI    = 5'd8;
    localparam logic [TYPE_W-1:0] TOK_STAR    = 5'd9;
    localparam logic [TYPE_W-1:0] TOK_BANG    = 5'd10;
    localparam logic [TYPE_W-1:0] TOK_BANGEQ  = 5'd11;
    localparam logic [TYPE_W-1:0] TOK_EQ      = 5'd12;
    localparam logic [TYPE_W-1:0] TOK_EQEQ    = 5'd13;
    localparam logic [TYPE_W-1:0] TOK_LESS    = 5'd14;
    localparam logic [TYPE_W-1:0] TOK_LESSEQ  = 5'd15;
    localparam logic [TYPE_W-1:0] TOK_GREATER = 5'd16;
    localparam logic [TYPE_W-1:0] TOK_GREQ    = 5'd17;
    localparam logic [TYPE_W-1:0] TOK_SLASH   = 5'd18;
    localparam logic [TYPE_W-1:0] TOK_STRING  = 5'd19;
    localparam logic [TYPE_W-1:0] TOK_NUMBER  = 5'd20;
    localparam logic [TYPE_W-1:0] TOK_EOF     = 5'd21;

    // error codes
    localparam logic ERR_UNEXPECTED   = 1'b0;
    localparam logic ERR_UNTERMINATED = 1'b1;

    // source characters
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    logic [2:0]             mode_reg, mode_next;
    logic [1:0]             op_reg, op_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;

    logic [OFFSET_BITS-1:0] pos_inc;
    logic [OFFSET_BITS-1:0] dot_pos;
    logic [OFFSET_BITS-1:0] span_pos;
    logic [OFFSET_BITS-1:0] span_inc;
    logic [OFFSET_BITS-1:0] span_dot;
    logic [LINE_BITS-1:0]   line_inc;
    logic                   is_digit;

    // clamped distance between two offsets
    function automatic logic [OFFSET_BITS-1:0] span(
        input logic [OFFSET_BITS-1:0] from,
        input logic [OFFSET_BITS-1:0] upto
    );
        return (upto > from) ? (upto - from) : '0;
    endfunction

    function automatic result_t make_res(
        input logic                   err,
        input logic                   code,
        input logic [TYPE_W-1:0]      ttype,
        input logic [OFFSET_BITS-1:0] start,
        input logic [OFFSET_BITS-1:0] len
    );
        result_t r;
        r.is_error   = err;
        r.error_code = code;
        r.tok_kind   = ttype;
        r.start      = FIELD_W'(start);
        r.length     = FIELD_W'(len);
        return r;
    endfunction

    // single-character form of a pending operator, the two-character form is one more
    function automatic logic [TYPE_W-1:0] op_type(input logic [1:0] op);
        logic [TYPE_W-1:0] t;
        unique case (op)
            OP_BANG:    t = TOK_BANG;
            OP_EQ:      t = TOK_EQ;
            OP_LESS:    t = TOK_LESS;
            OP_GREATER: t = TOK_GREATER;
            default:    t = TOK_BANG;
        endcase
        return t;
    endfunction

    // offset arithmetic shared by all modes
    assign pos_inc  = (off_reg == OFF_MAX) ? off_reg : off_reg + OFFSET_BITS'(1);
    assign dot_pos  = (off_reg != '0) ? off_reg - OFFSET_BITS'(1) : '0;
    assign span_pos = span(start_reg, off_reg);
    assign span_inc = span(start_reg, pos_inc);
    assign span_dot = span(start_reg, dot_pos);
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_BITS'(1);
    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);

    // classify the item and build its bundle
    always_comb
    begin
        logic [RIDX_W-1:0]      n;
        logic                   do_normal;
        result_t [MAX_RES-1:0]  res;

        n          = '0;
        do_normal  = 1'b0;
        res        = '0;
        mode_next  = mode_reg;
        op_next    = op_reg;
        start_next = start_reg;
        off_next   = off_reg;
        line_next  = line_reg;

        if (command)
        begin
            // finish: flush pending work, then end of file
            unique case (mode_reg)
                MODE_OP:
                begin
                    res[n] = make_res(1'b0, 1'b0, op_type(op_reg), start_reg, span_pos);
                    n = n + 1'b1;
                end
                MODE_SLASH:
                begin
                    res[n] = make_res(1'b0, 1'b0, TOK_SLASH, start_reg, span_pos);
                    n = n + 1'b1;
                end
                MODE_STRING:
                begin
                    res[n] = make_res(1'b1, ERR_UNTERMINATED, '0, start_reg, span_pos);
                    n = n + 1'b1;
                end
                MODE_INT, MODE_FRAC:
                begin
                    res[n] = make_res(1'b0, 1'b0, TOK_NUMBER, start_reg, span_pos);
                    n = n + 1'b1;
                end
                MODE_DOT:
                begin
                    res[n] = make_res(1'b0, 1'b0, TOK_NUMBER, start_reg, span_dot);
                    n = n + 1'b1;
                    res[n] = make_res(1'b0, 1'b0, TOK_DOT, dot_pos, OFFSET_BITS'(1));
                    n = n + 1'b1;
                end
                MODE_NORMAL, MODE_COMMENT:
                begin
                end
                default:
                begin
                end
            endcase
            res[n] = make_res(1'b0, 1'b0, TOK_EOF, off_reg, '0);
            n = n + 1'b1;
            mode_next  = MODE_NORMAL;
            op_next    = OP_BANG;
            start_next = '0;
            off_next   = '0;
            line_next  = LINE_BITS'(1);
        end
        else
        begin
            // character in the current mode
            unique case (mode_reg)
                MODE_OP:
                begin
                    if (char_code == CH_EQ)
                    begin
                        res[n] = make_res(1'b0, 1'b0, op_type(op_reg) + TYPE_W'(1),
                                          start_reg, span_inc);
                        n = n + 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                    else
                    begin
                        res[n] = make_res(1'b0, 1'b0, op_type(op_reg), start_reg, span_pos);
                        n = n + 1'b1;
                        do_normal = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (char_code == CH_SLASH)
                        mode_next = MODE_COMMENT;
                    else
                    begin
                        res[n] = make_res(1'b0, 1'b0, TOK_SLASH, start_reg, span_pos);
                        n = n + 1'b1;
                        do_normal = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_code == CH_NL)
                        do_normal = 1'b1;
                end
                MODE_STRING:
                begin
                    if (char_code == CH_QUOTE)
                    begin
                        res[n] = make_res(1'b0, 1'b0, TOK_STRING, start_reg, span_inc);
                        n = n + 1'b1;
                        mode_next = MODE_NORMAL;
                    end
                    else if (char_code == CH_NL)
                        line_next = line_inc;
                end
                MODE_INT:
                begin
                    if (char_code == CH_DOT)
                        mode_next = MODE_DOT;
                    else if (!is_digit)
                    begin
                        res[n] = make_res(1'b0, 1'b0, TOK_NUMBER, start_reg, span_pos);
                        n = n + 1'b1;
                        do_normal = 1'b1;
                    end
                end
                MODE_DOT:
                begin
                    if (is_digit)
                        mode_next = MODE_FRAC;
                    else
                    begin
                        res[n] = make_res(1'b0, 1'b0, TOK_NUMBER, start_reg, span_dot);
                        n = n + 1'b1;
                        res[n] = make_res(1'b0, 1'b0, TOK_DOT, dot_pos, OFFSET_BITS'(1));
                        n = n + 1'b1;
                        do_normal = 1'b1;
                    end
                end
                MODE_FRAC:
                begin
                    if (!is_digit)
                    begin
                        res[n] = make_res(1'b0, 1'b0, TOK_NUMBER, start_reg, span_pos);
                        n = n + 1'b1;
                        do_normal = 1'b1;
                    end
                end
                MODE_NORMAL:
                    do_normal = 1'b1;
                default:
                    do_normal = 1'b1;
            endcase

            // character seen from the normal mode
            if (do_normal)
            begin
                start_next = off_reg;
                mode_next  = MODE_NORMAL;
                unique case (char_code)
                    CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_COMMA,
                    CH_DOT, CH_MINUS, CH_PLUS, CH_SEMI, CH_STAR:
                    begin
                        unique case (char_code)
                            CH_LPAREN: res[n] = make_res(1'b0, 1'b0, TOK_LPAREN, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_RPAREN: res[n] = make_res(1'b0, 1'b0, TOK_RPAREN, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_LBRACE: res[n] = make_res(1'b0, 1'b0, TOK_LBRACE, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_RBRACE: res[n] = make_res(1'b0, 1'b0, TOK_RBRACE, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_COMMA:  res[n] = make_res(1'b0, 1'b0, TOK_COMMA, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_DOT:    res[n] = make_res(1'b0, 1'b0, TOK_DOT, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_MINUS:  res[n] = make_res(1'b0, 1'b0, TOK_MINUS, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_PLUS:   res[n] = make_res(1'b0, 1'b0, TOK_PLUS, off_reg,
                                                         OFFSET_BITS'(1));
                            CH_SEMI:   res[n] = make_res(1'b0, 1'b0, TOK_SEMI, off_reg,
                                                         OFFSET_BITS'(1));
                            default:   res[n] = make_res(1'b0, 1'b0, TOK_STAR, off_reg,
                                                         OFFSET_BITS'(1));
                        endcase
                        n = n + 1'b1;
                    end
                    CH_BANG:
                    begin
                        mode_next = MODE_OP;
                        op_next   = OP_BANG;
                    end
                    CH_EQ:
                    begin
                        mode_next = MODE_OP;
                        op_next   = OP_EQ;
                    end
                    CH_LESS:
                    begin
                        mode_next = MODE_OP;
                        op_next   = OP_LESS;
                    end
                    CH_GT:
                    begin
                        mode_next = MODE_OP;
                        op_next   = OP_GREATER;
                    end
                    CH_SLASH:
                        mode_next = MODE_SLASH;
                    CH_QUOTE:
                        mode_next = MODE_STRING;
                    CH_SPACE, CH_CR, CH_TAB:
                    begin
                    end
                    CH_NL:
                        line_next = line_inc;
                    default:
                    begin
                        if (is_digit)
                            mode_next = MODE_INT;
                        else
                        begin
                            res[n] = make_res(1'b1, ERR_UNEXPECTED, '0, off_reg,
                                              OFFSET_BITS'(1));
                            n = n + 1'b1;
                        end
                    end
                endcase
            end
            off_next = pos_inc;
        end

        // every result of one item carries the line count from before the item
        wr_data.count = n;
        wr_data.line  = FIELD_W'(line_reg);
        wr_data.res   = res;
        wr_en         = accept && (n != '0);
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            op_reg    <= OP_BANG;
            start_reg <= '0;
            off_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            op_reg    <= op_next;
            start_reg <= start_next;
            off_reg   <= off_next;
            line_reg  <= line_next;
        end
    end

    // checks
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count fell to zero");

    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |-> wr_en)
        else $error("finish produced no bundle");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command) |=> (off_reg == '0) && (mode_reg == MODE_NORMAL))
        else $error("finish did not restart the scanner");

endmodule

// ===== sv/lts_queue.sv =====
// ----------------------------------------------------------------------------
// lts_queue
// Short bundle queue between the scanner front end and the result back end.
// ----------------------------------------------------------------------------
module lts_queue
    import lts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    input  logic    rd_en,
    output logic    full,
    output logic    empty,
    output bundle_t rd_data
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bundle_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full))
        else $error("write into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && empty))
        else $error("read from empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill level beyond depth");

endmodule

// ===== sv/lts_back.sv =====
// ----------------------------------------------------------------------------
// lts_back
// Result back end: takes one bundle at a time and presents its results in
// order, one transfer per cycle while pop is high, marking the last one.
// ----------------------------------------------------------------------------
module lts_back
    import lts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  bundle_t             q_data,
    output logic                q_rd,
    input  logic                pop,
    output logic                empty,
    output logic                is_error,
    output logic                error_code,
    output logic [TYPE_W-1:0]   tok_kind,
    output logic [FIELD_W-1:0]  lexeme_start,
    output logic [FIELD_W-1:0]  lexeme_length,
    output logic [FIELD_W-1:0]  line_number,
    output logic                last_result
);

    bundle_t            cur_reg;
    logic               valid_reg;
    logic [RIDX_W-1:0]  idx_reg;
    logic               take;
    logic               is_last;
    result_t            res;

    assign is_last = (idx_reg == cur_reg.count - 1'b1);
    assign take    = pop && valid_reg;
    assign q_rd    = !q_empty && (!valid_reg || (take && is_last));

    // current result
    assign res           = cur_reg.res[idx_reg];
    assign empty         = !valid_reg;
    assign is_error      = res.is_error;
    assign error_code    = res.error_code;
    assign tok_kind      = res.tok_kind;
    assign lexeme_start  = res.start;
    assign lexeme_length = res.length;
    assign line_number   = cur_reg.line;
    assign last_result   = is_last;

    // bundle holding register
    always_ff @(posedge clk)
    begin
        if (q_rd)
            cur_reg <= q_data;
    end

    // result index and valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (q_rd)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (take && is_last)
            valid_reg <= 1'b0;
        else if (take)
            idx_reg <= idx_reg + 1'b1;
    end

    // checks
    a_idx_in_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (idx_reg < cur_reg.count))
        else $error("result index beyond bundle");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !pop) |=> valid_reg && $stable(idx_reg))
        else $error("result moved without a transfer");

    a_mid_bundle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !is_last) |=> valid_reg)
        else $error("bundle dropped before its last result");

endmodule

// ===== sv/lox_token_scanner.sv =====
// ----------------------------------------------------------------------------
// lox_token_scanner
// Streaming lexical scanner: one source byte or a finish command in, tokens
// and error reports out as type, offset, length and line.
//
//   port group   direction  handshake        payload
//   source       in         push / full      command, char_code
//   result       out        pop / empty      is_error, error_code, tok_kind,
//                                            lexeme_start, lexeme_length,
//                                            line_number, last_result
//
// One item is accepted per cycle while full is low; its results are written
// to the bundle queue in that same cycle. The result port gives one transfer
// per cycle while pop is high; the results of an item (from 0 to 3) travel
// together as one bundle. full rises only when the four-bundle queue is full;
// results pass through the queue memory and then the bundle holding register.
// Reset clears all control state at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module lox_token_scanner
    import lts_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic                command,
    input  logic [7:0]          char_code,
    output logic                empty,
    input  logic                pop,
    output logic                is_error,
    output logic                error_code,
    output logic [TYPE_W-1:0]   tok_kind,
    output logic [FIELD_W-1:0]  lexeme_start,
    output logic [FIELD_W-1:0]  lexeme_length,
    output logic [FIELD_W-1:0]  line_number,
    output logic                last_result
);

    logic    accept;
    logic    wr_en;
    bundle_t wr_data;
    logic    q_rd;
    logic    q_empty;
    bundle_t q_data;

    // input transfer
    assign accept = push && !full;

    lts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .char_code (char_code),
        .wr_en     (wr_en),
        .wr_data   (wr_data)
    );

    lts_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .rd_en   (q_rd),
        .full    (full),
        .empty   (q_empty),
        .rd_data (q_data)
    );

    lts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .is_error      (is_error),
        .error_code    (error_code),
        .tok_kind      (tok_kind),
        .lexeme_start  (lexeme_start),
        .lexeme_length (lexeme_length),
        .line_number   (line_number),
        .last_result   (last_result)
    );

endmodule
